// ===== design/acs_pkg.sv =====
// shared constants and types for the all-ones square counter
package acs_pkg;

    localparam int MAX_COLS = 512;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int SIDE_W   = 10;
    localparam int WIDTH_W  = 10;
    localparam int TOTAL_W  = 26;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = WIDTH_W'(MAX_COLS);

    typedef logic [COL_W-1:0]   col_t;
    typedef logic [SIDE_W-1:0]  side_t;
    typedef logic [WIDTH_W-1:0] width_t;
    typedef logic [TOTAL_W-1:0] total_t;

    // neighbor sizes that feed one cell
    typedef struct packed {
        logic  pixel;
        side_t left;
        side_t up;
        side_t diag;
    } cell_in_t;

endpackage

// ===== design/acs_line_ram.sv =====
// line store of the previous row's square sides, registered read
module acs_line_ram (
    input  logic           aclk,
    input  logic           wr_en,
    input  acs_pkg::col_t  wr_addr,
    input  acs_pkg::side_t wr_data,
    input  acs_pkg::col_t  rd_addr,
    output acs_pkg::side_t rd_data
);
    import acs_pkg::*;

    side_t mem [MAX_COLS];
    side_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/acs_cell_calc.sv =====
// square side for one cell and saturating update of the running total
module acs_cell_calc (
    input  acs_pkg::cell_in_t nbrs,
    input  acs_pkg::total_t   total_in,
    output acs_pkg::side_t    side,
    output acs_pkg::total_t   total_out
);
    import acs_pkg::*;

    side_t              min_lu;
    side_t              min_all;
    logic [TOTAL_W:0]   sum;

    always_comb begin
        min_lu  = (nbrs.left < nbrs.up) ? nbrs.left : nbrs.up;
        min_all = (min_lu < nbrs.diag) ? min_lu : nbrs.diag;
        side    = nbrs.pixel ? side_t'(min_all + side_t'(1)) : '0;
        sum     = {1'b0, total_in} + (TOTAL_W + 1)'(side);
        total_out = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end

endmodule

// ===== design/all_ones_square_counter_unit.sv =====
// top level of the all-ones square counter
// Takes one matrix bit per item in raster order and returns one item per bit: the side of the
// largest all-ones square ending at that cell, the saturating count of squares in the frame so
// far, and tlast when that count is final (copied from the input tlast). One item is accepted
// every clock cycle unless the output stalls; the previous row lives in a 512-entry line
// store read ahead of use; a back-to-back write and read of the same column is forwarded. After
// a row_width write that moves the pending column, input waits while the store is re-read.
module all_ones_square_counter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,      // row_width
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [0] pixel_bit, [7:1] zero
    input  logic        s_tlast,        // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,        // [9:0] square_side, [35:10] running_total, [39:36] zero
    output logic        m_tlast         // total_final
);
    import acs_pkg::*;

    width_t   row_width_reg;
    col_t     col_reg, col_next;
    logic     first_row_reg, first_row_next;
    side_t    left_reg, left_next;
    side_t    diag_reg, diag_next;
    total_t   total_reg, total_next;
    col_t     rd_addr_reg;
    logic     fwd_valid_reg;
    side_t    fwd_data_reg;

    logic     m_tvalid_reg;
    side_t    m_side_reg;
    total_t   m_total_reg;
    logic     m_last_reg;

    width_t   w_eff;
    logic     wrap;
    col_t     col_eff;
    logic     first_eff;
    side_t    up_mem;
    side_t    up;
    side_t    rd_data;
    cell_in_t nbrs;
    side_t    side;
    total_t   total_sum;
    logic     fire;
    logic     addr_ok;
    width_t   col_inc;
    col_t     rd_addr;

    always_comb begin
        if (row_width_reg == '0) begin
            w_eff = width_t'(1);
        end else if (row_width_reg > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = row_width_reg;
        end
    end

    // a narrower row width can leave the column past the end: start a new row
    assign wrap      = width_t'(col_reg) >= w_eff;
    assign col_eff   = wrap ? '0 : col_reg;
    assign first_eff = wrap ? 1'b0 : first_row_reg;

    assign up_mem = fwd_valid_reg ? fwd_data_reg : rd_data;
    assign up     = first_eff ? '0 : up_mem;

    assign nbrs.pixel = s_tdata[0];
    assign nbrs.left  = wrap ? '0 : left_reg;
    assign nbrs.diag  = wrap ? '0 : diag_reg;
    assign nbrs.up    = up;

    acs_cell_calc u_calc (
        .nbrs      (nbrs),
        .total_in  (total_reg),
        .side      (side),
        .total_out (total_sum)
    );

    // the prefetched line-store word must belong to the column about to be used
    assign addr_ok  = rd_addr_reg == col_eff;
    assign s_tready = addr_ok && (!m_tvalid_reg || m_tready);
    assign fire     = s_tvalid && s_tready;
    assign col_inc  = width_t'(col_eff) + width_t'(1);

    always_comb begin
        col_next       = col_reg;
        first_row_next = first_row_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        total_next     = total_reg;
        if (fire) begin
            total_next = total_sum;
            if (col_inc >= w_eff) begin
                col_next       = '0;
                first_row_next = 1'b0;
                left_next      = '0;
                diag_next      = '0;
            end else begin
                col_next       = col_inc[COL_W-1:0];
                first_row_next = first_eff;
                left_next      = side;
                diag_next      = up;
            end
            if (s_tlast) begin
                col_next       = '0;
                first_row_next = 1'b1;
                left_next      = '0;
                diag_next      = '0;
                total_next     = '0;
            end
        end
    end

    assign rd_addr = (width_t'(col_next) >= w_eff) ? '0 : col_next;

    acs_line_ram u_line_ram (
        .aclk    (aclk),
        .wr_en   (fire),
        .wr_addr (col_eff),
        .wr_data (side),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= WIDTH_MAX;
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            left_reg      <= '0;
            diag_reg      <= '0;
            total_reg     <= '0;
            rd_addr_reg   <= '0;
            fwd_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                row_width_reg <= cfg_wdata;
            end
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
            left_reg      <= left_next;
            diag_reg      <= diag_next;
            total_reg     <= total_next;
            rd_addr_reg   <= rd_addr;
            // same-column write and read in one cycle: the store returns the old word
            fwd_valid_reg <= fire && (rd_addr == col_eff);
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= side;
        if (fire) begin
            m_side_reg  <= side;
            m_total_reg <= total_sum;
            m_last_reg  <= s_tlast;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_total_reg, m_side_reg};
    assign m_tlast  = m_last_reg;

endmodule
